// File: rtl/idee_pkg.sv
package idee_pkg;

  // token codes
  localparam logic [2:0] OP_DIGIT  = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_EQUALS = 3'd5;
  localparam logic [2:0] OP_CLEAR  = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ORDER   = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_LIMIT   = 2'd3;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // steps of the shared unit
  localparam int MUL_STEPS = 4;
  localparam int DIV_STEPS = 16;

  typedef enum logic [1:0] {
    MUL_NONE   = 2'd0,
    MUL_TIMES  = 2'd1,
    MUL_DIVIDE = 2'd2
  } mul_op_t;

  // request into the multiply/divide unit
  typedef struct packed {
    logic start;
    logic divide;
  } mdu_req_t;

endpackage

// File: rtl/idee_tok_if.sv
interface idee_tok_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [3:0] digit;

  modport source (output valid, output operation, output digit, input ready);
  modport sink (input valid, input operation, input digit, output ready);
endinterface

// File: rtl/idee_res_if.sv
interface idee_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result;
  logic               result_valid;
  logic [1:0]         status;

  modport source (output valid, output result, output result_valid, output status,
                  input ready);
  modport sink (input valid, input result, input result_valid, input status,
                output ready);
endinterface

// File: rtl/idee_mdu.sv
module idee_mdu (
  input  logic               clk,
  input  logic               rst,
  input  idee_pkg::mdu_req_t req,
  input  logic [15:0]        a,
  input  logic [3:0]         d,
  output logic               done,
  output logic [15:0]        y
);

  typedef enum logic [1:0] {U_IDLE, U_ABS, U_RUN, U_FIX} ustate_t;

  ustate_t     state;
  logic        divide;
  logic        neg;
  logic [15:0] work;
  logic [15:0] mcand;
  logic [3:0]  dsr;
  logic [3:0]  rem;
  logic [3:0]  cnt;

  logic [15:0] add_x;
  logic [15:0] add_y;
  logic        add_sub;
  logic [16:0] sum;
  logic [4:0]  trial;
  logic        last;

  // the one shared adder: add, or subtract with carry out as x >= y
  always_comb begin
    trial   = {rem, work[15]};
    add_x   = work;
    add_y   = '0;
    add_sub = 1'b0;
    case (state)
      U_ABS, U_FIX: begin
        add_x   = '0;
        add_y   = work;
        add_sub = 1'b1;
      end
      U_RUN: begin
        if (divide) begin
          add_x   = {11'b0, trial};
          add_y   = {12'b0, dsr};
          add_sub = 1'b1;
        end else begin
          add_x = work;
          add_y = dsr[0] ? mcand : '0;
        end
      end
      default: begin
        add_x = work;
      end
    endcase
    sum  = {1'b0, add_x} + {1'b0, add_y ^ {16{add_sub}}} + {16'b0, add_sub};
    last = divide ? (cnt == 4'(idee_pkg::DIV_STEPS - 1))
                  : (cnt == 4'(idee_pkg::MUL_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        U_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            divide <= req.divide;
            dsr    <= d;
            cnt    <= '0;
            rem    <= '0;
            mcand  <= a;
            neg    <= req.divide & a[15];
            work   <= req.divide ? a : '0;
            state  <= req.divide ? U_ABS : U_RUN;
          end
        end
        U_ABS: begin
          // magnitude of the dividend
          done <= 1'b0;
          if (neg) begin
            work <= sum[15:0];
          end
          state <= U_RUN;
        end
        U_RUN: begin
          cnt  <= cnt + 4'd1;
          done <= last && !divide;
          if (divide) begin
            // restoring step, one quotient bit
            rem  <= sum[16] ? sum[3:0] : trial[3:0];
            work <= {work[14:0], sum[16]};
          end else begin
            // shift-add, one multiplier bit
            work  <= sum[15:0];
            mcand <= {mcand[14:0], 1'b0};
            dsr   <= {1'b0, dsr[3:1]};
          end
          if (last) begin
            if (divide) begin
              state <= U_FIX;
            end else begin
              y     <= sum[15:0];
              state <= U_IDLE;
            end
          end
        end
        U_FIX: begin
          // restore the sign, truncation toward zero
          y     <= neg ? sum[15:0] : work;
          done  <= 1'b1;
          state <= U_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= U_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/infix_digit_expression_evaluator_unit.sv
// a taken token's result word is registered as a pending word and then moved into the
// output register; a digit after multiply runs 4 shift-add steps and a digit after divide
// 16 restoring steps in between; one token at a time, the next is taken only once the
// last word is handed over, and a word held by the sink in the output register stalls
// the next word's hand-over, and so the token after it, until it drains
// reset: synchronous, active high; clears the expression state and empties the output
module infix_digit_expression_evaluator_unit #(
  parameter int MAX_ENTRIES = 20
) (
  input  logic        clk,
  input  logic        rst,
  idee_tok_if.sink    tok,
  idee_res_if.source  res
);

  typedef enum logic [1:0] {T_IDLE, T_MDU, T_OUT} tstate_t;

  tstate_t              state;

  // expression state
  logic [15:0]          running_sum;
  logic [15:0]          running_term;
  logic                 pending_minus;
  idee_pkg::mul_op_t    pending_mul;
  logic                 expect_digit;
  logic [4:0]           entry_count;

  // result word waiting for the output register
  logic [15:0]          pend_result;
  logic                 pend_rvalid;
  logic [1:0]           pend_status;

  // output register
  logic                 out_valid;
  logic [15:0]          out_result;
  logic                 out_rvalid;
  logic [1:0]           out_status;

  // token decode
  logic                 accept;
  logic                 limit_hit;
  logic [15:0]          closed;
  logic                 do_clear;
  logic                 load_digit;
  logic                 take_op;
  logic                 go_mdu;
  logic                 eq_done;
  logic [1:0]           dec_status;

  idee_pkg::mdu_req_t   mdu_req;
  logic                 mdu_done;
  logic [15:0]          mdu_y;

  assign accept    = tok.valid && tok.ready;
  assign tok.ready = (state == T_IDLE);
  assign limit_hit = (entry_count >= 5'(MAX_ENTRIES));

  // close the open term into the sum
  assign closed = pending_minus ? (running_sum - running_term)
                                : (running_sum + running_term);

  always_comb begin
    do_clear   = 1'b0;
    load_digit = 1'b0;
    take_op    = 1'b0;
    go_mdu     = 1'b0;
    eq_done    = 1'b0;
    dec_status = idee_pkg::ST_OK;
    case (tok.operation)
      idee_pkg::OP_CLEAR: begin
        do_clear = 1'b1;
      end
      idee_pkg::OP_DIGIT: begin
        if (!expect_digit || (tok.digit > idee_pkg::DIGIT_MAX)) begin
          dec_status = idee_pkg::ST_ORDER;
        end else if (limit_hit) begin
          do_clear   = 1'b1;
          dec_status = idee_pkg::ST_LIMIT;
        end else if ((pending_mul == idee_pkg::MUL_DIVIDE) && (tok.digit == 4'd0)) begin
          do_clear   = 1'b1;
          dec_status = idee_pkg::ST_DIVZERO;
        end else if (pending_mul == idee_pkg::MUL_NONE) begin
          load_digit = 1'b1;
        end else begin
          go_mdu = 1'b1;
        end
      end
      idee_pkg::OP_ADD, idee_pkg::OP_SUB, idee_pkg::OP_MUL, idee_pkg::OP_DIV: begin
        if (expect_digit) begin
          dec_status = idee_pkg::ST_ORDER;
        end else if (limit_hit) begin
          do_clear   = 1'b1;
          dec_status = idee_pkg::ST_LIMIT;
        end else begin
          take_op = 1'b1;
        end
      end
      idee_pkg::OP_EQUALS: begin
        if (expect_digit) begin
          dec_status = idee_pkg::ST_ORDER;
        end else begin
          eq_done  = 1'b1;
          do_clear = 1'b1;
        end
      end
      default: begin
        dec_status = idee_pkg::ST_ORDER;
      end
    endcase
  end

  // shared multiply/divide unit for digits after * or /
  assign mdu_req.start  = accept && go_mdu;
  assign mdu_req.divide = (pending_mul == idee_pkg::MUL_DIVIDE);

  idee_mdu u_mdu (
    .clk  (clk),
    .rst  (rst),
    .req  (mdu_req),
    .a    (running_term),
    .d    (tok.digit),
    .done (mdu_done),
    .y    (mdu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      running_sum   <= '0;
      running_term  <= '0;
      pending_minus <= 1'b0;
      pending_mul   <= idee_pkg::MUL_NONE;
      expect_digit  <= 1'b1;
      entry_count   <= '0;
      out_valid     <= 1'b0;
    end else begin
      // drained word empties the output register; in T_OUT the refill below decides
      if (res.valid && res.ready && (state != T_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            pend_status <= dec_status;
            pend_rvalid <= eq_done;
            pend_result <= eq_done ? closed : '0;
            state       <= go_mdu ? T_MDU : T_OUT;
            if (load_digit) begin
              running_term <= {12'b0, tok.digit};
              expect_digit <= 1'b0;
              entry_count  <= entry_count + 5'd1;
            end
            if (take_op) begin
              if ((tok.operation == idee_pkg::OP_ADD) ||
                  (tok.operation == idee_pkg::OP_SUB)) begin
                running_sum   <= closed;
                pending_minus <= (tok.operation == idee_pkg::OP_SUB);
                pending_mul   <= idee_pkg::MUL_NONE;
              end else begin
                pending_mul <= (tok.operation == idee_pkg::OP_MUL) ? idee_pkg::MUL_TIMES
                                                                   : idee_pkg::MUL_DIVIDE;
              end
              expect_digit <= 1'b1;
              entry_count  <= entry_count + 5'd1;
            end
            if (do_clear) begin
              running_sum   <= '0;
              running_term  <= '0;
              pending_minus <= 1'b0;
              pending_mul   <= idee_pkg::MUL_NONE;
              expect_digit  <= 1'b1;
              entry_count   <= '0;
            end
          end
        end
        T_MDU: begin
          // product or quotient becomes the open term
          if (mdu_done) begin
            running_term <= mdu_y;
            expect_digit <= 1'b0;
            entry_count  <= entry_count + 5'd1;
            state        <= T_OUT;
          end
        end
        T_OUT: begin
          // hand over once the output register is free or being drained
          if (!out_valid || res.ready) begin
            out_valid  <= 1'b1;
            out_result <= pend_result;
            out_rvalid <= pend_rvalid;
            out_status <= pend_status;
            state      <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign res.valid        = out_valid;
  assign res.result       = out_result;
  assign res.result_valid = out_rvalid;
  assign res.status       = out_status;

endmodule

// File: rtl/idee_chk.sv
module idee_chk (
  input logic        clk,
  input logic        rst,
  input logic        tok_valid,
  input logic        tok_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_result,
  input logic        res_result_valid,
  input logic [1:0]  res_status
);

  // result is zero unless an expression completed
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_result_valid || (res_result == 16'd0)))
    else $error("nonzero result without result_valid");

  // a completed expression always reports accepted
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_result_valid) |-> (res_status == idee_pkg::ST_OK))
    else $error("result_valid with error status");

  // one token at a time
  assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_ready) |=> !tok_ready)
    else $error("token taken while busy");

  // stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_result) &&
      $stable(res_result_valid) && $stable(res_status)))
    else $error("stalled result word changed");

endmodule

bind infix_digit_expression_evaluator_unit idee_chk u_idee_chk (
  .clk              (clk),
  .rst              (rst),
  .tok_valid        (tok.valid),
  .tok_ready        (tok.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_result       (res.result),
  .res_result_valid (res.result_valid),
  .res_status       (res.status)
);

// File: test/expression_checker.sv
`timescale 1ns / 100ps

module expression_checker #(
  parameter int MAX_ENTRIES = 20
) (
  input  logic clk,
  input  logic rst,
  idee_tok_if  tok,
  idee_res_if  res,
  output int   fail_count,
  output int   words_due
);

  typedef struct packed {
    logic signed [15:0] result;
    logic               result_valid;
    logic [1:0]         status;
  } calc_word_t;

  // mirror of the calculator state
  logic [15:0]       sum_closed;
  logic [15:0]       term_open;
  logic              subtract_term;
  idee_pkg::mul_op_t pending_op;
  logic              want_digit;
  logic [4:0]        entries;

  calc_word_t  expected_words [$];
  int          failures;
  int          words_checked;

  function automatic void clear_expression();
    sum_closed    = '0;
    term_open     = '0;
    subtract_term = 1'b0;
    pending_op    = idee_pkg::MUL_NONE;
    want_digit    = 1'b1;
    entries       = '0;
  endfunction

  function automatic logic [15:0] closed_sum();
    return subtract_term ? 16'(sum_closed - term_open) : 16'(sum_closed + term_open);
  endfunction

  // advances the mirrored state by one token and gives the word it should produce
  function automatic calc_word_t evaluate_token(logic [2:0] op, logic [3:0] d);
    calc_word_t word;
    int         quotient;
    word = '{result: '0, result_valid: 1'b0, status: idee_pkg::ST_OK};
    case (op)
      idee_pkg::OP_CLEAR: clear_expression();
      idee_pkg::OP_DIGIT: begin
        if (!want_digit || d > idee_pkg::DIGIT_MAX) begin
          word.status = idee_pkg::ST_ORDER;
        end else if (entries >= MAX_ENTRIES) begin
          clear_expression();
          word.status = idee_pkg::ST_LIMIT;
        end else if (pending_op == idee_pkg::MUL_DIVIDE && d == 4'd0) begin
          clear_expression();
          word.status = idee_pkg::ST_DIVZERO;
        end else begin
          case (pending_op)
            idee_pkg::MUL_TIMES: term_open = 16'(term_open * 16'(d));
            idee_pkg::MUL_DIVIDE: begin
              // int division truncates toward zero
              quotient  = int'($signed(term_open)) / int'(d);
              term_open = quotient[15:0];
            end
            default: term_open = 16'(d);
          endcase
          want_digit = 1'b0;
          entries    = entries + 5'd1;
        end
      end
      idee_pkg::OP_ADD, idee_pkg::OP_SUB, idee_pkg::OP_MUL, idee_pkg::OP_DIV: begin
        if (want_digit) begin
          word.status = idee_pkg::ST_ORDER;
        end else if (entries >= MAX_ENTRIES) begin
          clear_expression();
          word.status = idee_pkg::ST_LIMIT;
        end else begin
          if (op == idee_pkg::OP_ADD || op == idee_pkg::OP_SUB) begin
            sum_closed    = closed_sum();
            subtract_term = (op == idee_pkg::OP_SUB);
            pending_op    = idee_pkg::MUL_NONE;
          end else if (op == idee_pkg::OP_MUL) begin
            pending_op = idee_pkg::MUL_TIMES;
          end else begin
            pending_op = idee_pkg::MUL_DIVIDE;
          end
          want_digit = 1'b1;
          entries    = entries + 5'd1;
        end
      end
      idee_pkg::OP_EQUALS: begin
        if (want_digit) begin
          word.status = idee_pkg::ST_ORDER;
        end else begin
          word.result       = closed_sum();
          word.result_valid = 1'b1;
          clear_expression();
        end
      end
      default: word.status = idee_pkg::ST_ORDER;
    endcase
    return word;
  endfunction

  always @(posedge clk) begin
    calc_word_t seen;
    calc_word_t want;
    if (rst) begin
      clear_expression();
      expected_words.delete();
      failures      = 0;
      words_checked = 0;
    end else begin
      if (res.valid && res.ready) begin
        seen = '{result: res.result, result_valid: res.result_valid, status: res.status};
        if (expected_words.size() == 0) begin
          if (failures < 10)
            $display("unexpected result word: result %0d valid %0b status %0d",
                     seen.result, seen.result_valid, seen.status);
          failures++;
        end else begin
          want = expected_words.pop_front();
          if (seen.result !== want.result || seen.result_valid !== want.result_valid ||
              seen.status !== want.status) begin
            if (failures < 10)
              $display("word %0d: expected result %0d valid %0b status %0d",
                       words_checked, want.result, want.result_valid, want.status,
                       ", got result %0d valid %0b status %0d",
                       seen.result, seen.result_valid, seen.status);
            failures++;
          end
        end
        words_checked++;
      end
      if (tok.valid && tok.ready)
        expected_words.push_back(evaluate_token(tok.operation, tok.digit));
    end
    fail_count <= failures;
    words_due  <= expected_words.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // operation code the block does not use
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int MAX_ENTRIES   = 20;
  localparam int PHASE_TOKENS  = 400;
  // covers any word still in flight, also a digit after divide
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 500000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // idle rates in percent for the token sender and the result receiver
  int   send_idle;
  int   recv_idle;
  // long receiver hold-off so the output fills and the input backs up
  logic sink_hold = 1'b0;

  int   tokens_sent;
  int   cycle_count;
  int   fail_count;
  int   words_due;

  idee_tok_if tok ();
  idee_res_if res ();

  infix_digit_expression_evaluator_unit #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .tok(tok),
    .res(res)
  );

  expression_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .res       (res),
    .fail_count(fail_count),
    .words_due (words_due)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog: a run that hangs ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("infix_digit_expression_evaluator_unit: mismatch");
      $finish;
    end
  end

  // result receiver: random back-pressure, or held low for the whole hold-off
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= !sink_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  // offers one token word, with random idle cycles in front of it, and returns
  // right after the edge at which it was taken
  task automatic send_token(input logic [2:0] op, input logic [3:0] d);
    while ($urandom_range(99) < send_idle) begin
      tok.valid <= 1'b0;
      @(posedge clk);
    end
    tok.valid     <= 1'b1;
    tok.operation <= op;
    tok.digit     <= d;
    do @(posedge clk); while (!tok.ready);
    tokens_sent++;
  endtask

  // one keypad expression: digits alternating with operators, mostly short
  // enough to finish, now and then long enough to run past the entry limit;
  // stray tokens are sprinkled in and the ending is usually equals
  task automatic send_expression();
    logic [2:0] operators [4] = '{idee_pkg::OP_ADD, idee_pkg::OP_SUB,
                                  idee_pkg::OP_MUL, idee_pkg::OP_DIV};
    int         entries;
    int         ending;
    if ($urandom_range(99) < 80)
      entries = 2 * $urandom_range(9) + 1;
    else
      entries = $urandom_range(24, 19);
    for (int i = 0; i < entries; i++) begin
      // noise: any code, any digit value, out-of-range digits included
      if ($urandom_range(99) < 6)
        send_token(3'($urandom_range(7)), 4'($urandom));
      if (i % 2 == 0)
        send_token(idee_pkg::OP_DIGIT, 4'($urandom_range(9)));
      else
        send_token(operators[$urandom_range(3)], 4'($urandom));
    end
    ending = $urandom_range(99);
    // with no ending, an expression that ended on a digit leaves the next one opening on a misplaced digit
    if (ending < 85)
      send_token(idee_pkg::OP_EQUALS, 4'($urandom));
    else if (ending < 93)
      send_token(idee_pkg::OP_CLEAR, 4'($urandom));
  endtask

  initial begin
    logic [6:0] script [];
    int goal;

    // directed opening: misplaced and unused tokens, a multiply chain that
    // wraps negative followed by a divide that must truncate toward zero,
    // divide by zero, clear mid-expression and a plain subtraction
    script = '{
      {idee_pkg::OP_CLEAR,  4'd0},
      {idee_pkg::OP_EQUALS, 4'd0},   // equals on an empty expression
      {idee_pkg::OP_ADD,    4'd0},   // operator while a digit is due
      {OP_UNUSED,           4'd5},
      {idee_pkg::OP_DIGIT,  4'd15},  // digit out of range
      {idee_pkg::OP_DIGIT,  4'd9},
      {idee_pkg::OP_DIGIT,  4'd3},   // digit while an operator is due
      {idee_pkg::OP_MUL,    4'd0},
      {idee_pkg::OP_DIGIT,  4'd9},
      {idee_pkg::OP_MUL,    4'd0},
      {idee_pkg::OP_DIGIT,  4'd9},
      {idee_pkg::OP_MUL,    4'd0},
      {idee_pkg::OP_DIGIT,  4'd9},
      {idee_pkg::OP_MUL,    4'd0},
      {idee_pkg::OP_DIGIT,  4'd9},
      {idee_pkg::OP_DIV,    4'd0},
      {idee_pkg::OP_SUB,    4'd0},   // operator while a digit is due
      {idee_pkg::OP_DIGIT,  4'd2},
      {idee_pkg::OP_SUB,    4'd0},
      {idee_pkg::OP_DIGIT,  4'd8},
      {idee_pkg::OP_EQUALS, 4'd0},
      {idee_pkg::OP_DIGIT,  4'd0},
      {idee_pkg::OP_DIV,    4'd0},
      {idee_pkg::OP_DIGIT,  4'd0},   // divide by zero
      {idee_pkg::OP_DIGIT,  4'd7},
      {idee_pkg::OP_CLEAR,  4'd0},
      {idee_pkg::OP_DIGIT,  4'd0},
      {idee_pkg::OP_SUB,    4'd0},
      {idee_pkg::OP_DIGIT,  4'd9},
      {idee_pkg::OP_EQUALS, 4'd0}
    };

    send_idle     = 28;
    recv_idle     = 50;
    tok.valid     <= 1'b0;
    tok.operation <= idee_pkg::OP_CLEAR;
    tok.digit     <= 4'd0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send_token(script[i][6:4], script[i][3:0]);

    // three random phases: receiver sparse, sender sparse, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          fork
            begin
              repeat (500) @(posedge clk);
              sink_hold <= 1'b1;
              repeat (300) @(posedge clk);
              sink_hold <= 1'b0;
            end
          join_none
        end
        1: begin
          send_idle = 50;
          recv_idle = 28;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      goal = tokens_sent + PHASE_TOKENS;
      while (tokens_sent < goal)
        send_expression();
    end

    // drain: wait for every expected word, then let the block settle
    tok.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && words_due == 0)
      $display("infix_digit_expression_evaluator_unit: match");
    else
      $display("infix_digit_expression_evaluator_unit: mismatch");
    $finish;
  end

endmodule
